// File: hw/rtl/ctpd_pkg.sv
// ----------------------------------------------------------------------------
// ctpd_pkg
// Shared types and constants for the CD-Text pack decoder.
// ----------------------------------------------------------------------------
package ctpd_pkg;

    localparam int unsigned PackBytes = 18;
    localparam int unsigned TextFirst = 4;
    localparam int unsigned TextBytes = 12;
    localparam int unsigned PosW      = 5;
    localparam int unsigned TrackW    = 8;
    localparam int unsigned TcW       = 7;
    localparam int unsigned ByteW     = 8;

    localparam logic [PosW-1:0] PosFirst    = PosW'(0);
    localparam logic [PosW-1:0] PosHeader   = PosW'(1);
    localparam logic [PosW-1:0] PosTextLo   = PosW'(TextFirst);
    localparam logic [PosW-1:0] PosTextHi   = PosW'(TextFirst + TextBytes - 1);
    localparam logic [PosW-1:0] PosLast     = PosW'(PackBytes - 1);

    localparam logic [ByteW-1:0]  CodeTitle  = 8'h80;
    localparam logic [ByteW-1:0]  CodePerf   = 8'h81;
    localparam logic [ByteW-1:0]  TrackMask  = 8'h7F;
    localparam logic [TrackW-1:0] TrackMax   = 8'hFF;

    typedef enum logic [1:0] {
        KIND_TITLE = 2'd0,
        KIND_PERF  = 2'd1,
        KIND_OTHER = 2'd2
    } t_kind;

    // One accepted input byte.
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             start_of_area;
    } t_item;

    // One decoded text character.
    typedef struct packed {
        logic             text_kind;
        logic [TcW-1:0]   track_index;
        logic [ByteW-1:0] text_char;
    } t_result;

endpackage

// File: hw/rtl/ctpd_in_reg.sv
// ----------------------------------------------------------------------------
// ctpd_in_reg
// Input holding register: captures one byte and releases it to the decoder.
// ----------------------------------------------------------------------------
module ctpd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ctpd_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output ctpd_pkg::t_item o_item
);
    import ctpd_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // The register frees up in the same cycle the decoder takes its byte.
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/ctpd_core.sv
// ----------------------------------------------------------------------------
// ctpd_core
// Pack framing, kind tracking and per-kind track counters.
// ----------------------------------------------------------------------------
module ctpd_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  ctpd_pkg::t_item           i_item,
    input  logic [ctpd_pkg::TcW-1:0]  i_track_count,
    output logic                      o_emit,
    output ctpd_pkg::t_result         o_result
);
    import ctpd_pkg::*;

    logic [PosW-1:0]   r_pos;
    t_kind             r_kind;
    logic [TrackW-1:0] r_track  [2];
    logic [1:0]        r_seeded;

    logic [PosW-1:0]   n_pos;
    t_kind             n_kind;
    logic [TrackW-1:0] n_track  [2];
    logic [1:0]        n_seeded;

    logic [PosW-1:0]   cur_pos;
    t_kind             cur_kind;
    logic [TrackW-1:0] cur_track [2];
    logic [1:0]        cur_seeded;
    logic              k;
    logic              in_text;
    logic [ByteW-1:0]  b;

    always_comb begin
        b = i_item.data_byte;
        // A start-of-area byte sees cleared state and counts as byte 0.
        if (i_item.start_of_area) begin
            cur_pos      = PosFirst;
            cur_kind     = KIND_OTHER;
            cur_track[0] = '0;
            cur_track[1] = '0;
            cur_seeded   = '0;
        end else begin
            cur_pos      = r_pos;
            cur_kind     = r_kind;
            cur_track[0] = r_track[0];
            cur_track[1] = r_track[1];
            cur_seeded   = r_seeded;
        end

        k       = cur_kind[0];
        in_text = (cur_pos >= PosTextLo) && (cur_pos <= PosTextHi);

        n_kind     = cur_kind;
        n_track[0] = cur_track[0];
        n_track[1] = cur_track[1];
        n_seeded   = cur_seeded;
        o_emit     = 1'b0;

        o_result.text_kind   = k;
        o_result.track_index = cur_track[k][TcW-1:0];
        o_result.text_char   = b;

        if (cur_pos == PosFirst) begin
            unique case (b)
                CodeTitle: n_kind = KIND_TITLE;
                CodePerf:  n_kind = KIND_PERF;
                default:   n_kind = KIND_OTHER;
            endcase
        end else if (cur_kind != KIND_OTHER) begin
            if (cur_pos == PosHeader) begin
                if (!cur_seeded[k]) begin
                    n_track[k]  = b & TrackMask;
                    n_seeded[k] = 1'b1;
                end
            end else if (in_text) begin
                if (b == '0) begin
                    if (cur_track[k] != TrackMax) begin
                        n_track[k] = cur_track[k] + TrackW'(1);
                    end
                end else begin
                    o_emit = cur_seeded[k]
                          && (cur_track[k] <= {1'b0, i_track_count});
                end
            end
        end

        n_pos = (cur_pos == PosLast) ? PosFirst : cur_pos + PosW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= PosFirst;
            r_kind     <= KIND_OTHER;
            r_track[0] <= '0;
            r_track[1] <= '0;
            r_seeded   <= '0;
        end else if (i_fire) begin
            r_pos      <= n_pos;
            r_kind     <= n_kind;
            r_track[0] <= n_track[0];
            r_track[1] <= n_track[1];
            r_seeded   <= n_seeded;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosLast)
        else $error("pack position out of range");

    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_item.start_of_area && (r_pos == PosLast) |=> r_pos == PosFirst)
        else $error("pack position did not wrap");

    a_emit_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_emit |-> (cur_track[k] <= {1'b0, i_track_count})
                          && (o_result.text_char != '0))
        else $error("character emitted beyond track count or as zero");

    a_emit_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> in_text && (cur_kind != KIND_OTHER) && cur_seeded[k])
        else $error("character emitted outside a seeded text window");

endmodule

// File: hw/rtl/ctpd_out_reg.sv
// ----------------------------------------------------------------------------
// ctpd_out_reg
// Result register toward the output stream, held while the receiver stalls.
// ----------------------------------------------------------------------------
module ctpd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_emit,
    input  ctpd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output ctpd_pkg::t_result o_result
);
    import ctpd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load ? i_emit : (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: hw/rtl/cd_text_pack_decoder.sv
// ----------------------------------------------------------------------------
// cd_text_pack_decoder
// Extracts title and performer characters from a CD-Text pack byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries the pack area one byte per transfer, whole
//   18-byte packs in order. tuser marks the first byte of an area; that byte
//   clears the position, pack kind and both track counters first.
//   The master stream carries one transfer per emitted text character: its
//   kind in tuser (0 title, 1 performer), the track and the character in
//   tdata. Bytes that yield no character produce no transfer.
//   The user writes the track count through i_cfg_we / i_cfg_wdata while the
//   block is idle (not enforced); characters for higher tracks are dropped.
// Timing:
//   One byte per cycle sustained while the result register is not held by a
//   stalled receiver. A byte is captured in the input register, decoded
//   combinationally into the result register once that register is free,
//   and its character is presented on the master stream from there.
// Reset and stalls:
//   Synchronous active-low reset clears the valid flags of both stream
//   registers, the decoder state and the track count. When the receiver
//   holds tready low on a pending result, the result register holds, the
//   decoder waits, and the input register fills and then drops s_axis_tready.
// ----------------------------------------------------------------------------
module cd_text_pack_decoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]               s_axis_tuser,  // [0] start_of_area
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata,  // [6:0] track_index, [14:7] text_char
    output logic [0:0]               m_axis_tuser,  // [0] text_kind
    input  logic                     i_cfg_we,
    input  logic [ctpd_pkg::TcW-1:0] i_cfg_wdata
);
    import ctpd_pkg::*;

    t_item         in_item;
    t_item         reg_item;
    logic          reg_valid;
    logic          out_free;
    logic          fire;
    logic          emit;
    t_result       core_result;
    t_result       out_result;
    logic [TcW-1:0] r_track_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= '0;
        end else if (i_cfg_we) begin
            r_track_count <= i_cfg_wdata;
        end
    end

    assign in_item.data_byte     = s_axis_tdata;
    assign in_item.start_of_area = s_axis_tuser[0];

    // The decoder advances whenever it holds a byte and the result slot frees.
    assign fire = reg_valid && out_free;

    ctpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (reg_valid),
        .o_item  (reg_item)
    );

    ctpd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (reg_item),
        .i_track_count (r_track_count),
        .o_emit        (emit),
        .o_result      (core_result)
    );

    ctpd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_emit   (emit),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {1'b0, out_result.text_char, out_result.track_index};
    assign m_axis_tuser = out_result.text_kind;

endmodule
